### design/stg_pkg.sv
// Shared types and constants for the sinusoid trajectory generator.
// No dependencies; imported by every stg_* module and the top level.
`timescale 1ns / 1ps
`default_nettype none

package stg_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_OFFSET    = 2'd0,
		REG_AMPLITUDE = 2'd1,
		REG_FREQUENCY = 2'd2,
		REG_PHASE     = 2'd3
	} stg_reg_t;

	localparam int          SIN_WIDTH  = 15;
	localparam int          W_WIDTH    = 35;
	localparam logic [18:0] TWO_PI_Q16 = 19'd411775;

	// Per-word control carried down the pipeline
	typedef struct packed {
		logic valid;
		logic sin_neg;
		logic cos_neg;
	} stg_ctl_t;

endpackage

`default_nettype wire

### design/stg_phase.sv
// Phase accumulation and quarter-wave address generation (stages 1 and 2).
// Depends on stg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stg_phase import stg_pkg::*; #(
	parameter int TBITS = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [31:0]      time_now,
	input  logic [31:0]      frequency,
	input  logic [31:0]      phase_turns,
	output logic [TBITS-2:0] sin_addr_s2,
	output logic [TBITS-2:0] cos_addr_s2,
	output stg_ctl_t         ctl_s2
);

	localparam int QBITS = TBITS - 2;
	localparam logic [QBITS:0] QTR_SIZE = {1'b1, {QBITS{1'b0}}};

	logic             valid_s1;
	logic [31:0]      prod_s1;
	logic [31:0]      phase;
	logic [TBITS-1:0] k;
	logic [1:0]       quad_s;
	logic [1:0]       quad_c;
	logic [QBITS:0]   r_ext;
	logic [QBITS:0]   r_mir;

	assign phase  = phase_turns + prod_s1;
	assign k      = phase[31 -: TBITS];
	assign quad_s = k[TBITS-1 -: 2];
	assign quad_c = quad_s + 2'd1;
	assign r_ext  = {1'b0, k[QBITS-1:0]};
	assign r_mir  = QTR_SIZE - r_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ctl_s2   <= '0;
		end else begin
			valid_s1       <= accept;
			ctl_s2.valid   <= valid_s1;
			ctl_s2.sin_neg <= quad_s[1];
			ctl_s2.cos_neg <= quad_c[1];
		end
	end

	always_ff @(posedge clk) begin
		prod_s1     <= frequency * time_now;
		sin_addr_s2 <= quad_s[0] ? r_mir : r_ext;
		cos_addr_s2 <= quad_c[0] ? r_mir : r_ext;
	end

endmodule

`default_nettype wire

### design/stg_sine_rom.sv
// Quarter-wave sine ROM, two registered read ports (stage 3).
// Contents built at elaboration; depends on stg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stg_sine_rom import stg_pkg::*; #(
	parameter int TBITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [TBITS-2:0]     sin_addr,
	input  logic [TBITS-2:0]     cos_addr,
	input  stg_ctl_t             ctl_in,
	output logic [SIN_WIDTH-1:0] sin_mag_s3,
	output logic [SIN_WIDTH-1:0] cos_mag_s3,
	output stg_ctl_t             ctl_s3
);

	localparam int QBITS    = TBITS - 2;
	localparam int QTR_SIZE = 1 << QBITS;
	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

	typedef logic [SIN_WIDTH-1:0] rom_t [QTR_SIZE+1];

	function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] rem;
		q   = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem  = rem - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [SIN_WIDTH-1:0] quarter_sine(input logic [31:0] m);
		logic [63:0]  x;
		logic [63:0]  x2;
		logic [63:0]  term;
		logic [63:0]  sum;
		logic [63:0]  val;
		logic [127:0] prod;
		x    = ((HALF_PI_Q62 >> 16) * {32'd0, m}) << (18 - TBITS);
		prod = {64'd0, x} * {64'd0, x};
		x2   = prod[125:62];
		term = x;
		sum  = x;
		for (int n = 1; n <= 13; n++) begin
			if (term != 64'd0) begin
				prod = {64'd0, term} * {64'd0, x2};
				term = div_u64(prod[125:62], 64'(2 * n) * 64'(2 * n + 1));
				if (n % 2 == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
		end
		val = ((sum >> 16) * 64'd32767 + (64'd1 << 45)) >> 46;
		if (val > 64'd32767) begin
			val = 64'd32767;
		end
		return val[SIN_WIDTH-1:0];
	endfunction

	function automatic rom_t build_rom();
		rom_t t;
		for (int m = 0; m <= QTR_SIZE; m++) begin
			t[m] = quarter_sine(32'(m));
		end
		return t;
	endfunction

	localparam rom_t ROM = build_rom();

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		sin_mag_s3 <= ROM[sin_addr];
		cos_mag_s3 <= ROM[cos_addr];
	end

endmodule

`default_nettype wire

### design/stg_amp.sv
// Amplitude scaling of sine and cosine, magnitude and sign form (stage 4).
// Depends on stg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stg_amp import stg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [31:0]          amplitude,
	input  logic [SIN_WIDTH-1:0] sin_mag,
	input  logic [SIN_WIDTH-1:0] cos_mag,
	input  stg_ctl_t             ctl_in,
	output logic [31:0]          ms_s4,
	output logic [31:0]          mc_s4,
	output stg_ctl_t             ctl_s4
);

	logic        aneg;
	logic [31:0] amag;
	logic [46:0] ps;
	logic [46:0] pc;

	assign aneg = amplitude[31];
	assign amag = aneg ? (32'd0 - amplitude) : amplitude;
	assign ps   = 47'(amag) * 47'(sin_mag) + 47'd16384;
	assign pc   = 47'(amag) * 47'(cos_mag) + 47'd16384;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else begin
			ctl_s4.valid   <= ctl_in.valid;
			ctl_s4.sin_neg <= aneg ^ (ctl_in.sin_neg && (sin_mag != '0));
			ctl_s4.cos_neg <= aneg ^ (ctl_in.cos_neg && (cos_mag != '0));
		end
	end

	always_ff @(posedge clk) begin
		ms_s4 <= ps[46:15];
		mc_s4 <= pc[46:15];
	end

endmodule

`default_nettype wire

### design/stg_deriv.sv
// Position, velocity and acceleration with saturation (stages 5 to 8).
// Depends on stg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stg_deriv import stg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        offset,
	input  logic [W_WIDTH-1:0] w,
	input  logic [31:0]        ms,
	input  logic [31:0]        mc,
	input  stg_ctl_t           ctl_in,
	output logic signed [31:0] position,
	output logic signed [47:0] velocity,
	output logic signed [47:0] acceleration,
	output logic               saturated,
	output logic               done
);

	localparam logic [69:0] LIM = 70'd1 << 47;

	function automatic logic [48:0] sat48(input logic neg, input logic [69:0] mag);
		logic [47:0] v;
		logic        f;
		f = 1'b0;
		if (neg) begin
			if (mag > LIM) begin
				v = 48'h8000_0000_0000;
				f = 1'b1;
			end else begin
				v = 48'd0 - mag[47:0];
			end
		end else begin
			if (mag >= LIM) begin
				v = 48'h7FFF_FFFF_FFFF;
				f = 1'b1;
			end else begin
				v = mag[47:0];
			end
		end
		return {f, v};
	endfunction

	stg_ctl_t    ctl_s5, ctl_s6, ctl_s7;
	logic [33:0] pos_s5;
	logic [50:0] vlo_s5, vhi_s5, tlo_s5, thi_s5;
	logic [31:0] pos_s6, pos_s7;
	logic        psat_s6, psat_s7;
	logic [51:0] vm_s6;
	logic [49:0] tmp_s6;
	logic [47:0] vel_s7;
	logic        vsat_s7;
	logic [51:0] a0_s7, a1_s7;
	logic [50:0] a2_s7;

	logic [33:0] off_ext, ms_ext, pos_sum;
	logic [67:0] v_full, t_full;
	logic [85:0] a_full;
	logic [48:0] vel_c, acc_c;

	assign off_ext = {{2{offset[31]}}, offset};
	assign ms_ext  = {2'b00, ms};
	assign pos_sum = ctl_in.sin_neg ? (off_ext - ms_ext) : (off_ext + ms_ext);

	assign v_full = {1'b0, vhi_s5, 16'd0} + 68'(vlo_s5) + 68'd32768;
	assign t_full = {1'b0, thi_s5, 16'd0} + 68'(tlo_s5) + 68'd32768;

	assign vel_c  = sat48(ctl_s6.cos_neg, 70'(vm_s6));
	assign a_full = 86'(a0_s7) + (86'(a1_s7) << 17) + (86'(a2_s7) << 34) + 86'd32768;
	assign acc_c  = sat48(!ctl_s7.sin_neg, a_full[85:16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			done   <= 1'b0;
		end else begin
			ctl_s5 <= ctl_in;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			done   <= ctl_s7.valid;
		end
	end

	always_ff @(posedge clk) begin
		pos_s5 <= pos_sum;
		vlo_s5 <= 51'(w) * 51'(mc[15:0]);
		vhi_s5 <= 51'(w) * 51'(mc[31:16]);
		tlo_s5 <= 51'(w) * 51'(ms[15:0]);
		thi_s5 <= 51'(w) * 51'(ms[31:16]);

		vm_s6  <= v_full[67:16];
		tmp_s6 <= t_full[65:16];
		if (pos_s5[33:31] == 3'b000 || pos_s5[33:31] == 3'b111) begin
			pos_s6  <= pos_s5[31:0];
			psat_s6 <= 1'b0;
		end else begin
			pos_s6  <= pos_s5[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			psat_s6 <= 1'b1;
		end

		a0_s7   <= 52'(w) * 52'(tmp_s6[16:0]);
		a1_s7   <= 52'(w) * 52'(tmp_s6[33:17]);
		a2_s7   <= 51'(w) * 51'(tmp_s6[49:34]);
		vel_s7  <= vel_c[47:0];
		vsat_s7 <= vel_c[48];
		pos_s7  <= pos_s6;
		psat_s7 <= psat_s6;

		position     <= pos_s7;
		velocity     <= vel_s7;
		acceleration <= acc_c[47:0];
		saturated    <= psat_s7 | vsat_s7 | acc_c[48];
	end

endmodule

`default_nettype wire

### design/sinusoid_trajectory_generator_top.sv
// Top level of the sinusoid trajectory generator: config registers and pipeline.
// Depends on stg_pkg, stg_phase, stg_sine_rom, stg_amp and stg_deriv.
//
// Usage:
//   Configuration: cfg_write with cfg_index (0 offset, 1 amplitude, 2 frequency,
//   3 phase_turns) and cfg_data writes a register at the clock edge; write only
//   while no word is in flight.
//   Input: a time_now word is taken at every edge with start high and busy low.
//   busy never rises, so a new word may enter every cycle.
//   Output: done is high for one cycle with position, velocity, acceleration
//   and saturated valid; the receiver cannot stall the block.
//   Pipeline: done is registered in the last of eight register stages (phase
//   multiply, address, ROM read, amplitude multiply, two split derivative
//   multiplies each followed by a sum and saturate), the first of which loads
//   at the accepting edge.
//   Throughput: one word per cycle.
//   Reset: arst_n clears the config registers and the valid bits, which
//   empties the pipeline; data registers hold until overwritten.
`timescale 1ns / 1ps
`default_nettype none

module sinusoid_trajectory_generator_top import stg_pkg::*; #(
	parameter int SINE_TABLE_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic [31:0]        time_now,
	output logic               done,
	output logic signed [31:0] position,
	output logic signed [47:0] velocity,
	output logic signed [47:0] acceleration,
	output logic               saturated
);

	logic [31:0]        offset_q, amplitude_q, frequency_q, phase_q;
	logic [W_WIDTH-1:0] w_q;
	logic [50:0]        w_full;

	logic [SINE_TABLE_BITS-2:0] sin_addr_s2, cos_addr_s2;
	logic [SIN_WIDTH-1:0]       sin_mag_s3, cos_mag_s3;
	logic [31:0]                ms_s4, mc_s4;
	stg_ctl_t                   ctl_s2, ctl_s3, ctl_s4;

	assign busy   = 1'b0;
	assign w_full = 51'(frequency_q) * 51'(TWO_PI_Q16) + 51'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			amplitude_q <= '0;
			frequency_q <= '0;
			phase_q     <= '0;
			w_q         <= '0;
		end else begin
			w_q <= w_full[50:16];
			if (cfg_write) begin
				case (cfg_index)
					REG_OFFSET:    offset_q    <= cfg_data;
					REG_AMPLITUDE: amplitude_q <= cfg_data;
					REG_FREQUENCY: frequency_q <= cfg_data;
					REG_PHASE:     phase_q     <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	stg_phase #(.TBITS(SINE_TABLE_BITS)) u_phase (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (start & ~busy),
		.time_now    (time_now),
		.frequency   (frequency_q),
		.phase_turns (phase_q),
		.sin_addr_s2 (sin_addr_s2),
		.cos_addr_s2 (cos_addr_s2),
		.ctl_s2      (ctl_s2)
	);

	stg_sine_rom #(.TBITS(SINE_TABLE_BITS)) u_rom (
		.clk        (clk),
		.arst_n     (arst_n),
		.sin_addr   (sin_addr_s2),
		.cos_addr   (cos_addr_s2),
		.ctl_in     (ctl_s2),
		.sin_mag_s3 (sin_mag_s3),
		.cos_mag_s3 (cos_mag_s3),
		.ctl_s3     (ctl_s3)
	);

	stg_amp u_amp (
		.clk       (clk),
		.arst_n    (arst_n),
		.amplitude (amplitude_q),
		.sin_mag   (sin_mag_s3),
		.cos_mag   (cos_mag_s3),
		.ctl_in    (ctl_s3),
		.ms_s4     (ms_s4),
		.mc_s4     (mc_s4),
		.ctl_s4    (ctl_s4)
	);

	stg_deriv u_deriv (
		.clk          (clk),
		.arst_n       (arst_n),
		.offset       (offset_q),
		.w            (w_q),
		.ms           (ms_s4),
		.mc           (mc_s4),
		.ctl_in       (ctl_s4),
		.position     (position),
		.velocity     (velocity),
		.acceleration (acceleration),
		.saturated    (saturated),
		.done         (done)
	);

endmodule

`default_nettype wire
